FILE: hdl/vgl_pkg.sv
// Package with shared widths, register indexes, state codes and types of the grid layout block.
`default_nettype none
package vgl_pkg;
    localparam int DIM_W = 13;
    localparam int CNT_W = 5;
    localparam int NUM_W = 2 * DIM_W;
    localparam int ACC_W = NUM_W + CNT_W;

    typedef enum logic [1:0] {
        REG_IMAGE_WIDTH     = 2'd0,
        REG_IMAGE_HEIGHT    = 2'd1,
        REG_VIEWPORT_WIDTH  = 2'd2,
        REG_VIEWPORT_HEIGHT = 2'd3
    } t_reg_idx;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL,
        S_GROW,
        S_DIV_TW,
        S_DIV_TH,
        S_DIV_W,
        S_DIV_H,
        S_DIV_SX,
        S_DIV_SY,
        S_OUT
    } t_state;

    typedef struct packed {
        logic [DIM_W-1:0] image_width;
        logic [DIM_W-1:0] image_height;
        logic [DIM_W-1:0] viewport_width;
        logic [DIM_W-1:0] viewport_height;
    } t_cfg;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_status;
endpackage
`default_nettype wire

FILE: hdl/vgl_div.sv
// Bit-serial restoring divider: one quotient bit per cycle, most significant first.
`default_nettype none
module vgl_div (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_start,
    input  wire logic [vgl_pkg::NUM_W-1:0]     i_num,
    input  wire logic [vgl_pkg::DIM_W-1:0]     i_den,
    output vgl_pkg::t_div_status               o_status,
    output logic      [vgl_pkg::NUM_W-1:0]     o_quo,
    output logic      [vgl_pkg::DIM_W-1:0]     o_rem
);
    localparam int NW = vgl_pkg::NUM_W;
    localparam int DW = vgl_pkg::DIM_W;

    logic          r_busy, n_busy;
    logic          r_done, n_done;
    logic [4:0]    r_cnt, n_cnt;
    logic [NW-1:0] r_sh, n_sh;
    logic [DW-1:0] r_rem, n_rem;
    logic [DW-1:0] r_den, n_den;
    logic [DW:0]   w_trial;
    logic          w_ge;
    logic [DW:0]   w_diff;

    always_comb begin
        w_trial = {r_rem, r_sh[NW-1]};
        w_ge    = (w_trial >= {1'b0, r_den});
        w_diff  = w_trial - {1'b0, r_den};
        n_busy  = r_busy;
        n_done  = 1'b0;
        n_cnt   = r_cnt;
        n_sh    = r_sh;
        n_rem   = r_rem;
        n_den   = r_den;
        if (i_start && !r_busy) begin
            n_busy = 1'b1;
            n_cnt  = 5'(NW - 1);
            n_sh   = i_num;
            n_rem  = '0;
            n_den  = i_den;
        end else if (r_busy) begin
            n_sh  = {r_sh[NW-2:0], w_ge};
            n_rem = w_ge ? w_diff[DW-1:0] : w_trial[DW-1:0];
            if (r_cnt == 5'd0) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end else begin
                n_cnt = r_cnt - 5'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_sh  <= n_sh;
        r_rem <= n_rem;
        r_den <= n_den;
    end

    assign o_status.busy = r_busy;
    assign o_status.done = r_done;
    assign o_quo         = r_sh;
    assign o_rem         = r_rem;
endmodule
`default_nettype wire

FILE: hdl/vgl_cfg.sv
// APB register file holding the image and viewport sizes.
`default_nettype none
module vgl_cfg (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_psel,
    input  wire logic        i_penable,
    input  wire logic        i_pwrite,
    input  wire logic [3:0]  i_paddr,
    input  wire logic [31:0] i_pwdata,
    output logic      [31:0] o_prdata,
    output logic             o_pready,
    output vgl_pkg::t_cfg    o_cfg
);
    localparam int DW = vgl_pkg::DIM_W;

    vgl_pkg::t_cfg    r_cfg, n_cfg;
    vgl_pkg::t_reg_idx w_idx;
    logic             w_wr;

    always_comb begin
        w_idx = vgl_pkg::t_reg_idx'(i_paddr[3:2]);
        w_wr  = i_psel && i_penable && i_pwrite;
        n_cfg = r_cfg;
        if (w_wr) begin
            unique case (w_idx)
                vgl_pkg::REG_IMAGE_WIDTH:     n_cfg.image_width     = i_pwdata[DW-1:0];
                vgl_pkg::REG_IMAGE_HEIGHT:    n_cfg.image_height    = i_pwdata[DW-1:0];
                vgl_pkg::REG_VIEWPORT_WIDTH:  n_cfg.viewport_width  = i_pwdata[DW-1:0];
                vgl_pkg::REG_VIEWPORT_HEIGHT: n_cfg.viewport_height = i_pwdata[DW-1:0];
                default:                      n_cfg = r_cfg;
            endcase
        end
        unique case (w_idx)
            vgl_pkg::REG_IMAGE_WIDTH:     o_prdata = 32'(r_cfg.image_width);
            vgl_pkg::REG_IMAGE_HEIGHT:    o_prdata = 32'(r_cfg.image_height);
            vgl_pkg::REG_VIEWPORT_WIDTH:  o_prdata = 32'(r_cfg.viewport_width);
            vgl_pkg::REG_VIEWPORT_HEIGHT: o_prdata = 32'(r_cfg.viewport_height);
            default:                      o_prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.image_width     <= 13'd1;
            r_cfg.image_height    <= 13'd1;
            r_cfg.viewport_width  <= 13'd1920;
            r_cfg.viewport_height <= 13'd1080;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_pready = 1'b1;
    assign o_cfg    = r_cfg;
endmodule
`default_nettype wire

FILE: hdl/viewport_grid_letterbox_layout_top.sv
// Top level: grid search sequencer, shared serial divider and tile output register.
// Sequence: the products are formed first, then the grid grows by a row or a column per step
// until its cells cover the source count; four serial divisions follow, and each tile adds
// two such divisions and an output step.
// One request is worked at a time; a request of zero sources gives no transfer.
// Synchronous active-low reset returns to idle with the reset register values.
`default_nettype none
module viewport_grid_letterbox_layout_top #(
    parameter int MAX_SOURCES = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [4:0]  i_source_count,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic      [3:0]  o_tile_index,
    output logic      [12:0] o_rect_x,
    output logic      [12:0] o_rect_y,
    output logic      [12:0] o_rect_w,
    output logic      [12:0] o_rect_h,
    output logic             o_last_tile
);
    localparam int DW   = vgl_pkg::DIM_W;
    localparam int CW   = vgl_pkg::CNT_W;
    localparam int NW   = vgl_pkg::NUM_W;
    localparam int AW   = vgl_pkg::ACC_W;
    localparam int NSAT = (MAX_SOURCES > 31) ? 31 : MAX_SOURCES;

    vgl_pkg::t_cfg        w_cfg;
    vgl_pkg::t_div_status w_div;
    logic [NW-1:0]        w_quo;
    logic [DW-1:0]        w_rem;
    logic                 w_start;
    logic [NW-1:0]        w_num;
    logic [DW-1:0]        w_den;

    vgl_pkg::t_state r_state, n_state;
    logic [CW-1:0]   r_n, n_n;
    logic [CW-1:0]   r_cols, n_cols;
    logic [CW-1:0]   r_rows, n_rows;
    logic [NW-1:0]   r_a, n_a;
    logic [NW-1:0]   r_b, n_b;
    logic [AW-1:0]   r_l, n_l;
    logic [AW-1:0]   r_r, n_r;
    logic [DW-1:0]   r_tw, n_tw;
    logic [DW-1:0]   r_th, n_th;
    logic [DW-1:0]   r_w, n_w;
    logic [DW-1:0]   r_h, n_h;
    logic [DW-1:0]   r_offx, n_offx;
    logic [DW-1:0]   r_offy, n_offy;
    logic [DW-1:0]   r_sx, n_sx;
    logic [DW-1:0]   r_y, n_y;
    logic [CW-1:0]   r_i, n_i;
    logic [CW-1:0]   r_col, n_col;
    logic [CW-1:0]   r_row, n_row;
    logic            r_out_valid, n_out_valid;
    logic [3:0]      r_o_idx, n_o_idx;
    logic [DW-1:0]   r_o_x, n_o_x;
    logic [DW-1:0]   r_o_y, n_o_y;
    logic [DW-1:0]   r_o_w, n_o_w;
    logic [DW-1:0]   r_o_h, n_o_h;
    logic            r_o_last, n_o_last;

    logic [DW-1:0]   w_ow, w_oh;
    logic [CW-1:0]   w_nsat;
    logic [9:0]      w_cells;
    logic            w_rnd;
    logic [DW-1:0]   w_round_q;
    logic [DW-1:0]   w_clamp;
    logic [DW-1:0]   w_sy;
    logic            w_div_state;

    vgl_cfg u_cfg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_psel    (psel),
        .i_penable (penable),
        .i_pwrite  (pwrite),
        .i_paddr   (paddr),
        .i_pwdata  (pwdata),
        .o_prdata  (prdata),
        .o_pready  (pready),
        .o_cfg     (w_cfg)
    );

    vgl_div u_div (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (w_start),
        .i_num    (w_num),
        .i_den    (w_den),
        .o_status (w_div),
        .o_quo    (w_quo),
        .o_rem    (w_rem)
    );

    // An image of zero area is fitted as if it were one pixel square.
    always_comb begin
        if (w_cfg.image_width == '0 || w_cfg.image_height == '0) begin
            w_ow = DW'(1);
            w_oh = DW'(1);
        end else begin
            w_ow = w_cfg.image_width;
            w_oh = w_cfg.image_height;
        end
        w_nsat  = (i_source_count > CW'(NSAT)) ? CW'(NSAT) : i_source_count;
        w_cells = 10'(r_cols) * 10'(r_rows);
        // Round half to even on the finished quotient and remainder.
        w_rnd = ({1'b0, w_rem} << 1) > (DW + 1)'(w_den)
             || ((({1'b0, w_rem} << 1) == (DW + 1)'(w_den)) && w_quo[0]);
        w_round_q = w_quo[DW-1:0] + DW'(w_rnd);
        w_sy = w_quo[DW-1:0];
    end

    always_comb begin
        w_div_state = 1'b0;
        w_num       = '0;
        w_den       = DW'(1);
        unique case (r_state)
            vgl_pkg::S_DIV_TW: begin
                w_div_state = 1'b1;
                w_num = NW'(w_cfg.viewport_width);
                w_den = DW'(r_cols);
            end
            vgl_pkg::S_DIV_TH: begin
                w_div_state = 1'b1;
                w_num = NW'(w_cfg.viewport_height);
                w_den = DW'(r_rows);
            end
            vgl_pkg::S_DIV_W: begin
                w_div_state = 1'b1;
                w_num = NW'(w_ow) * NW'(r_th);
                w_den = w_oh;
            end
            vgl_pkg::S_DIV_H: begin
                w_div_state = 1'b1;
                w_num = NW'(w_oh) * NW'(r_tw);
                w_den = w_ow;
            end
            vgl_pkg::S_DIV_SX: begin
                w_div_state = 1'b1;
                w_num = NW'(w_cfg.viewport_width) * NW'(r_col);
                w_den = DW'(r_cols);
            end
            vgl_pkg::S_DIV_SY: begin
                w_div_state = 1'b1;
                w_num = NW'(w_cfg.viewport_height) * NW'(r_row);
                w_den = DW'(r_rows);
            end
            default: begin
                w_div_state = 1'b0;
            end
        endcase
        w_start = w_div_state && !w_div.busy && !w_div.done;
    end

    always_comb begin
        n_state     = r_state;
        n_n         = r_n;
        n_cols      = r_cols;
        n_rows      = r_rows;
        n_a         = r_a;
        n_b         = r_b;
        n_l         = r_l;
        n_r         = r_r;
        n_tw        = r_tw;
        n_th        = r_th;
        n_w         = r_w;
        n_h         = r_h;
        n_offx      = r_offx;
        n_offy      = r_offy;
        n_sx        = r_sx;
        n_y         = r_y;
        n_i         = r_i;
        n_col       = r_col;
        n_row       = r_row;
        n_out_valid = r_out_valid && i_out_stall;
        n_o_idx     = r_o_idx;
        n_o_x       = r_o_x;
        n_o_y       = r_o_y;
        n_o_w       = r_o_w;
        n_o_h       = r_o_h;
        n_o_last    = r_o_last;
        w_clamp     = '0;
        o_in_stall  = (r_state != vgl_pkg::S_IDLE);
        unique case (r_state)
            vgl_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_n    = w_nsat;
                    n_cols = CW'(1);
                    n_rows = CW'(1);
                    n_i    = '0;
                    n_col  = '0;
                    n_row  = '0;
                    if (w_nsat != '0) begin
                        n_state = vgl_pkg::S_MUL;
                    end
                end
            end
            vgl_pkg::S_MUL: begin
                n_a     = NW'(w_cfg.image_width) * NW'(w_cfg.viewport_height);
                n_b     = NW'(w_cfg.image_height) * NW'(w_cfg.viewport_width);
                n_l     = AW'(n_a);
                n_r     = AW'(n_b);
                n_state = vgl_pkg::S_GROW;
            end
            vgl_pkg::S_GROW: begin
                // The scaled aspect sums track iw*vh*cols and ih*vw*rows.
                if (w_cells >= 10'(r_n)) begin
                    n_state = vgl_pkg::S_DIV_TW;
                end else if (r_l > r_r) begin
                    n_rows = r_rows + CW'(1);
                    n_r    = r_r + AW'(r_b);
                end else begin
                    n_cols = r_cols + CW'(1);
                    n_l    = r_l + AW'(r_a);
                end
            end
            vgl_pkg::S_DIV_TW: begin
                if (w_div.done) begin
                    n_tw    = w_round_q;
                    n_state = vgl_pkg::S_DIV_TH;
                end
            end
            vgl_pkg::S_DIV_TH: begin
                if (w_div.done) begin
                    n_th    = w_round_q;
                    n_state = vgl_pkg::S_DIV_W;
                end
            end
            vgl_pkg::S_DIV_W: begin
                if (w_div.done) begin
                    w_clamp = (w_quo > NW'(r_tw)) ? r_tw : w_quo[DW-1:0];
                    n_w     = w_clamp;
                    n_offx  = DW'((r_tw - w_clamp) >> 1);
                    n_state = vgl_pkg::S_DIV_H;
                end
            end
            vgl_pkg::S_DIV_H: begin
                if (w_div.done) begin
                    w_clamp = (w_quo > NW'(r_th)) ? r_th : w_quo[DW-1:0];
                    n_h     = w_clamp;
                    n_offy  = DW'((r_th - w_clamp) >> 1);
                    n_state = vgl_pkg::S_DIV_SX;
                end
            end
            vgl_pkg::S_DIV_SX: begin
                if (w_div.done) begin
                    n_sx    = w_quo[DW-1:0];
                    n_state = vgl_pkg::S_DIV_SY;
                end
            end
            vgl_pkg::S_DIV_SY: begin
                if (w_div.done) begin
                    n_y     = w_sy + r_offy;
                    n_state = vgl_pkg::S_OUT;
                end
            end
            vgl_pkg::S_OUT: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid = 1'b1;
                    n_o_idx     = r_i[3:0];
                    n_o_x       = r_sx + r_offx;
                    n_o_y       = r_y;
                    n_o_w       = r_w;
                    n_o_h       = r_h;
                    n_o_last    = (r_i + CW'(1) == r_n);
                    if (r_i + CW'(1) == r_n) begin
                        n_state = vgl_pkg::S_IDLE;
                    end else begin
                        n_i = r_i + CW'(1);
                        if (r_row + CW'(1) == r_rows) begin
                            n_row = '0;
                            n_col = r_col + CW'(1);
                        end else begin
                            n_row = r_row + CW'(1);
                        end
                        n_state = vgl_pkg::S_DIV_SX;
                    end
                end
            end
            default: begin
                n_state = vgl_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= vgl_pkg::S_IDLE;
            r_out_valid <= 1'b0;
            r_cols      <= CW'(1);
            r_rows      <= CW'(1);
            r_i         <= '0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_cols      <= n_cols;
            r_rows      <= n_rows;
            r_i         <= n_i;
        end
        r_n      <= n_n;
        r_a      <= n_a;
        r_b      <= n_b;
        r_l      <= n_l;
        r_r      <= n_r;
        r_tw     <= n_tw;
        r_th     <= n_th;
        r_w      <= n_w;
        r_h      <= n_h;
        r_offx   <= n_offx;
        r_offy   <= n_offy;
        r_sx     <= n_sx;
        r_y      <= n_y;
        r_col    <= n_col;
        r_row    <= n_row;
        r_o_idx  <= n_o_idx;
        r_o_x    <= n_o_x;
        r_o_y    <= n_o_y;
        r_o_w    <= n_o_w;
        r_o_h    <= n_o_h;
        r_o_last <= n_o_last;
    end

    assign o_out_valid  = r_out_valid;
    assign o_tile_index = r_o_idx;
    assign o_rect_x     = r_o_x;
    assign o_rect_y     = r_o_y;
    assign o_rect_w     = r_o_w;
    assign o_rect_h     = r_o_h;
    assign o_last_tile  = r_o_last;

`ifndef ASSERT_OFF
    a_grid_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cols != '0) && (r_rows != '0))
        else $error("grid dimension became zero");
    a_tile_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == vgl_pkg::S_OUT) |-> (r_i < r_n))
        else $error("tile counter ran past the source count");
    a_div_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_start |-> (!w_div.busy && w_div_state))
        else $error("divider started while busy");
    a_fit_within_tile: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == vgl_pkg::S_OUT) |-> (r_w <= r_tw) && (r_h <= r_th))
        else $error("fitted image exceeds its tile");
`endif
endmodule
`default_nettype wire
